// ===== design/tcc_pkg.sv =====
// Shared constants, types and limits of the text console cursor controller.
package tcc_pkg;

  // Build-time screen size ceilings
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 128;

  // Widths of the cursor, the size registers and the configuration port
  localparam int COL_W  = 8;
  localparam int ROW_W  = 7;
  localparam int NCOL_W = 9;
  localparam int NROW_W = 8;
  localparam int CODE_W = 8;
  localparam int GLYPH_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  // Effective ceilings: the configured ceiling, capped by what the cursor can hold
  localparam int COL_TOP_I = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int ROW_TOP_I = (MAX_ROWS < 128) ? MAX_ROWS : 128;
  localparam logic [NCOL_W-1:0] COL_TOP = NCOL_W'(COL_TOP_I);
  localparam logic [NROW_W-1:0] ROW_TOP = NROW_W'(ROW_TOP_I);

  // Register reset values
  localparam logic [NCOL_W-1:0] NUM_COLS_RST = 9'd80;
  localparam logic [NROW_W-1:0] NUM_ROWS_RST = 8'd25;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd1;

  // Character codes
  localparam logic [CODE_W-1:0]  CODE_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0]  CODE_BACKSPACE = 8'd8;
  localparam logic [GLYPH_W-1:0] CODE_SPACE     = 7'd32;
  localparam logic [GLYPH_W-1:0] CODE_QUESTION  = 7'd63;

  // One result word
  typedef struct packed {
    logic               draw_valid;
    logic [COL_W-1:0]   draw_col;
    logic [ROW_W-1:0]   draw_row;
    logic [GLYPH_W-1:0] draw_code;
    logic               scroll;
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
  } result_t;

endpackage

// ===== design/text_console_cursor.sv =====
// Top level of the text console cursor controller.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    char_code
//   result    out        out_valid / out_ready  draw_*, scroll, cursor_*
//   config    in         cfg_wen                cfg_index, cfg_wdata
//
// One character is taken per cycle while the result side does not stall; its result word appears in the next cycle.
// The cursor update is combinational; the result register is the only register on the path.
// A new character is taken while the held word is being taken out.
// A stall on the result side holds the word and blocks the input side.
// Reset clears the cursor to the top left cell and loads an 80 by 25 screen.
module text_console_cursor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tcc_pkg::CODE_W-1:0]     char_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           draw_valid,
  output logic [tcc_pkg::COL_W-1:0]      draw_col,
  output logic [tcc_pkg::ROW_W-1:0]      draw_row,
  output logic [tcc_pkg::GLYPH_W-1:0]    draw_code,
  output logic                           scroll,
  output logic [tcc_pkg::COL_W-1:0]      cursor_col,
  output logic [tcc_pkg::ROW_W-1:0]      cursor_row,
  input  logic                           cfg_wen,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tcc_pkg::*;

  logic [NCOL_W-1:0] num_cols;
  logic [NROW_W-1:0] num_rows;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  result_t           res_next;
  result_t           res;
  logic              accept;

  // Write the size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= NUM_COLS_RST;
      num_rows <= NUM_ROWS_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_NUM_COLS: num_cols <= cfg_wdata[NCOL_W-1:0];
        REG_NUM_ROWS: num_rows <= cfg_wdata[NROW_W-1:0];
        default: ;
      endcase
    end
  end

  tcc_step u_step (
    .code     (char_code),
    .cur_col  (cur_col),
    .cur_row  (cur_row),
    .num_cols (num_cols),
    .num_rows (num_rows),
    .res      (res_next)
  );

  tcc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_in    (res_next),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res)
  );

  assign accept = in_valid && in_ready;

  // Advance the cursor on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (accept) begin
      cur_col <= res_next.cursor_col;
      cur_row <= res_next.cursor_row;
    end
  end

  assign draw_valid = res.draw_valid;
  assign draw_col   = res.draw_col;
  assign draw_row   = res.draw_row;
  assign draw_code  = res.draw_code;
  assign scroll     = res.scroll;
  assign cursor_col = res.cursor_col;
  assign cursor_row = res.cursor_row;

`ifndef SYNTHESIS
  // The held word always reports the live cursor
  a_cursor_tracks : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_col == cur_col) && (cursor_row == cur_row))
    else $error("held cursor differs from cursor state");

  // A newline gives a no-draw word at column zero
  a_newline : assert property (@(posedge clk) disable iff (rst)
    accept && (char_code == CODE_NEWLINE) |=> out_valid && !draw_valid && (cursor_col == '0))
    else $error("newline result wrong");

  // A word without a draw carries empty draw fields
  a_no_draw_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !draw_valid |-> (draw_col == '0) && (draw_row == '0) && (draw_code == '0))
    else $error("draw fields set without draw");
`endif

endmodule

// ===== design/tcc_step.sv =====
// Combinational cursor update for one character against the current cursor.
module tcc_step (
  input  logic [tcc_pkg::CODE_W-1:0] code,
  input  logic [tcc_pkg::COL_W-1:0]  cur_col,
  input  logic [tcc_pkg::ROW_W-1:0]  cur_row,
  input  logic [tcc_pkg::NCOL_W-1:0] num_cols,
  input  logic [tcc_pkg::NROW_W-1:0] num_rows,
  output tcc_pkg::result_t           res
);
  import tcc_pkg::*;

  logic [NCOL_W-1:0] cols;
  logic [NROW_W-1:0] rows;
  logic [NCOL_W-1:0] col_inc;
  logic [NCOL_W-1:0] col_n;
  logic [NROW_W-1:0] row_n;
  logic [NROW_W-1:0] row_inc;
  logic [NROW_W-1:0] row_last;

  // Clamp the screen size to one cell at least and to the ceiling at most
  always_comb begin
    if (num_cols == '0) begin
      cols = NCOL_W'(1);
    end else if (num_cols > COL_TOP) begin
      cols = COL_TOP;
    end else begin
      cols = num_cols;
    end
    if (num_rows == '0) begin
      rows = NROW_W'(1);
    end else if (num_rows > ROW_TOP) begin
      rows = ROW_TOP;
    end else begin
      rows = num_rows;
    end
  end

  assign col_inc  = {1'b0, cur_col} + NCOL_W'(1);
  assign row_inc  = {1'b0, cur_row} + NROW_W'(1);
  assign row_last = rows - NROW_W'(1);

  // Move the cursor and pick the glyph to draw
  always_comb begin
    res   = '0;
    col_n = {1'b0, cur_col};
    row_n = {1'b0, cur_row};
    if (code == CODE_NEWLINE) begin
      col_n = '0;
      row_n = row_inc;
    end else if (code == CODE_BACKSPACE) begin
      if (cur_col != '0) begin
        col_n          = {1'b0, cur_col} - NCOL_W'(1);
        res.draw_valid = 1'b1;
        res.draw_col   = col_n[COL_W-1:0];
        res.draw_row   = cur_row;
        res.draw_code  = CODE_SPACE;
      end
    end else begin
      res.draw_valid = 1'b1;
      res.draw_col   = cur_col;
      res.draw_row   = cur_row;
      res.draw_code  = code[CODE_W-1] ? CODE_QUESTION : code[GLYPH_W-1:0];
      // Wrap to the next row at the column limit
      if (col_inc >= cols) begin
        col_n = '0;
        row_n = row_inc;
      end else begin
        col_n = col_inc;
      end
    end
    // Scroll once the row runs past the last row
    if (row_n >= rows) begin
      res.scroll = 1'b1;
      row_n      = row_last;
    end
    res.cursor_col = col_n[COL_W-1:0];
    res.cursor_row = row_n[ROW_W-1:0];
  end

endmodule

// ===== design/tcc_out_reg.sv =====
// Result register with the valid/ready handshake on both sides.
module tcc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcc_pkg::result_t res_in,
  output logic             out_valid,
  input  logic             out_ready,
  output tcc_pkg::result_t res_out
);
  import tcc_pkg::*;

  logic load;

  // Take a new word when the register is empty or is being emptied
  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
